// ===== hdl/nscan_pkg.sv =====
package nscan_pkg;

    localparam int MAX_PACKET_BYTES = 65536;
    localparam int POS_W = 16;
    localparam logic [POS_W-1:0] POS_TOP =
        (MAX_PACKET_BYTES - 1 < 65535) ? POS_W'(MAX_PACKET_BYTES - 1) : {POS_W{1'b1}};
    localparam logic [7:0] TYPE_MASK = 8'h1f;
    localparam logic [1:0] ZERO_RUN_TOP = 2'd3;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [0:0] {
        EV_UNIT_START = 1'b0,
        EV_PACKET_END = 1'b1
    } event_kind_t;

    typedef struct packed {
        event_kind_t       event_kind;
        logic [4:0]        nal_type;
        logic [POS_W-1:0]  unit_offset;
        logic [POS_W-1:0]  prev_end_offset;
        logic              prev_in_packet;
        logic [1:0]        strip_prev;
        logic [1:0]        trailing_zeros;
        logic              type_pending;
        logic              last;
    } nal_result_t;

    typedef struct packed {
        logic [1:0]   count;
        nal_result_t  first;
        nal_result_t  second;
    } result_push_t;

    function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] p);
        sat_inc = (p >= POS_TOP) ? POS_TOP : p + POS_W'(1);
    endfunction

endpackage

// ===== hdl/nscan_byte_if.sv =====
interface nscan_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       packet_start;
    logic       packet_end;

    modport source (output valid, output data_byte, output packet_start,
                    output packet_end, input ready);
    modport sink (input valid, input data_byte, input packet_start,
                  input packet_end, output ready);
endinterface

// ===== hdl/nscan_event_if.sv =====
interface nscan_event_if;
    logic                        valid;
    logic                        ready;
    logic                        event_kind;
    logic [4:0]                  nal_type;
    logic [nscan_pkg::POS_W-1:0] unit_offset;
    logic [nscan_pkg::POS_W-1:0] prev_end_offset;
    logic                        prev_in_packet;
    logic [1:0]                  strip_prev;
    logic [1:0]                  trailing_zeros;
    logic                        type_pending;
    logic                        last;

    modport source (output valid, output event_kind, output nal_type, output unit_offset,
                    output prev_end_offset, output prev_in_packet, output strip_prev,
                    output trailing_zeros, output type_pending, output last,
                    input ready);
    modport sink (input valid, input event_kind, input nal_type, input unit_offset,
                  input prev_end_offset, input prev_in_packet, input strip_prev,
                  input trailing_zeros, input type_pending, input last,
                  output ready);
endinterface

// ===== hdl/nal_start_code_scanner_core.sv =====
// Scans PES payload bytes for Annex B start codes at one byte per clock. Each
// accepted byte is decoded in the cycle it is taken and its results (none, one,
// or two when a type byte is also the packet's last byte) land in a four-entry
// result queue in the next cycle. stream.ready stays high while the queue has room
// for two results, so bytes flow at one per cycle as long as nal_events drains
// at least as fast as results are made; a byte that yields two results gives
// two events on nal_events and the queue absorbs the difference.
module nal_start_code_scanner_core
(
    input  logic         clk,
    input  logic         rst_n,
    nscan_byte_if.sink   stream,
    nscan_event_if.source nal_events
);

    logic                            accept;
    logic                            pop;
    nscan_pkg::result_push_t         push;
    nscan_pkg::nal_result_t          head;
    logic [nscan_pkg::QCNT_W-1:0]    q_count;

    assign stream.ready = (q_count <= nscan_pkg::QCNT_W'(nscan_pkg::QDEPTH - 2));
    assign accept       = stream.valid && stream.ready;
    assign pop          = nal_events.valid && nal_events.ready;

    nscan_scanner u_scanner
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .data_byte    (stream.data_byte),
        .packet_start (stream.packet_start),
        .packet_end   (stream.packet_end),
        .push         (push)
    );

    nscan_result_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .count (q_count)
    );

    assign nal_events.valid           = (q_count != '0);
    assign nal_events.event_kind      = head.event_kind;
    assign nal_events.nal_type        = head.nal_type;
    assign nal_events.unit_offset     = head.unit_offset;
    assign nal_events.prev_end_offset = head.prev_end_offset;
    assign nal_events.prev_in_packet  = head.prev_in_packet;
    assign nal_events.strip_prev      = head.strip_prev;
    assign nal_events.trailing_zeros  = head.trailing_zeros;
    assign nal_events.type_pending    = head.type_pending;
    assign nal_events.last            = head.last;

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= nscan_pkg::QCNT_W'(nscan_pkg::QDEPTH))
        else $error("result queue overflow");

    a_end_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && stream.packet_end) |=> nal_events.valid)
        else $error("packet end byte gave no result");

    a_idle_byte_count: assert property (@(posedge clk) disable iff (!rst_n)
        (push.count == 2'd0 && !pop) |=> $stable(q_count))
        else $error("queue count moved without push or pop");

endmodule

// ===== hdl/nscan_scanner.sv =====
module nscan_scanner
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     accept,
    input  logic [7:0]               data_byte,
    input  logic                     packet_start,
    input  logic                     packet_end,
    output nscan_pkg::result_push_t  push
);

    typedef struct packed {
        logic [nscan_pkg::POS_W-1:0] end_off;
        logic                        in_packet;
        logic [1:0]                  strip;
    } prev_t;

    logic [1:0]                  zero_run_reg, zero_run_next;
    logic                        awaiting_reg, awaiting_next;
    logic [nscan_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                        open_reg, open_next;
    logic [1:0]                  carry_reg, carry_next;

    logic [nscan_pkg::POS_W-1:0] p;
    logic [nscan_pkg::POS_W-1:0] p_inc;
    logic                        open_eff;
    logic [1:0]                  carry_eff;
    prev_t                       prev_at_p;
    prev_t                       prev_at_inc;

    function automatic prev_t fill_prev(
        input logic [nscan_pkg::POS_W-1:0] i,
        input logic [1:0]                  z,
        input logic                        uo,
        input logic [1:0]                  cr
    );
        prev_t r;
        r.end_off   = ({1'b0, i} >= (17'(z) + 17'd1)) ?
                      (i - nscan_pkg::POS_W'(z) - nscan_pkg::POS_W'(1)) : '0;
        r.in_packet = uo;
        r.strip     = (!uo && cr != 2'd0 && ({1'b0, i} + 17'(cr)) <= 17'd4) ? cr : 2'd0;
        fill_prev   = r;
    endfunction

    assign p         = packet_start ? '0 : pos_reg;
    assign p_inc     = nscan_pkg::sat_inc(p);
    assign open_eff  = packet_start ? 1'b0 : open_reg;
    assign carry_eff = packet_start ? (awaiting_reg ? 2'd0 : zero_run_reg) : carry_reg;
    assign prev_at_p   = fill_prev(p, zero_run_reg, open_eff, carry_eff);
    assign prev_at_inc = fill_prev(p_inc, zero_run_reg, open_eff, carry_eff);

    always_comb
    begin
        nscan_pkg::nal_result_t unit_r;
        nscan_pkg::nal_result_t end_r;

        zero_run_next = zero_run_reg;
        awaiting_next = awaiting_reg;
        open_next     = open_eff;
        carry_next    = carry_eff;
        pos_next      = p_inc;

        unit_r            = '0;
        unit_r.event_kind = nscan_pkg::EV_UNIT_START;
        unit_r.nal_type   = 5'(data_byte & nscan_pkg::TYPE_MASK);
        unit_r.unit_offset = p;
        if (!packet_start)
        begin
            unit_r.prev_end_offset = prev_at_p.end_off;
            unit_r.prev_in_packet  = prev_at_p.in_packet;
            unit_r.strip_prev      = prev_at_p.strip;
        end

        if (awaiting_reg)
        begin
            open_next     = 1'b1;
            awaiting_next = 1'b0;
            zero_run_next = (packet_start || data_byte != 8'd0) ? 2'd0 : 2'd1;
        end
        else if (zero_run_reg < 2'd2)
        begin
            zero_run_next = (data_byte != 8'd0) ? 2'd0 : zero_run_reg + 2'd1;
        end
        else if (data_byte == 8'd0)
        begin
            zero_run_next = nscan_pkg::ZERO_RUN_TOP;
        end
        else if (data_byte == 8'd1)
        begin
            awaiting_next = 1'b1;
        end
        else
        begin
            zero_run_next = 2'd0;
        end

        end_r            = '0;
        end_r.event_kind = nscan_pkg::EV_PACKET_END;
        end_r.last       = 1'b1;
        if (awaiting_next)
        begin
            end_r.prev_end_offset = prev_at_inc.end_off;
            end_r.prev_in_packet  = prev_at_inc.in_packet;
            end_r.strip_prev      = prev_at_inc.strip;
            end_r.type_pending    = 1'b1;
        end
        else
        begin
            end_r.prev_end_offset = p_inc;
            end_r.prev_in_packet  = open_next;
            end_r.trailing_zeros  = zero_run_next;
        end

        unit_r.last = !packet_end;

        push = '0;
        if (accept)
        begin
            if (awaiting_reg)
            begin
                push.first  = unit_r;
                push.second = end_r;
                push.count  = packet_end ? 2'd2 : 2'd1;
            end
            else if (packet_end)
            begin
                push.first = end_r;
                push.count = 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_run_reg <= '0;
            awaiting_reg <= 1'b0;
            pos_reg      <= '0;
            open_reg     <= 1'b0;
            carry_reg    <= '0;
        end
        else if (accept)
        begin
            zero_run_reg <= zero_run_next;
            awaiting_reg <= awaiting_next;
            pos_reg      <= pos_next;
            open_reg     <= open_next;
            carry_reg    <= carry_next;
        end
    end

endmodule

// ===== hdl/nscan_result_queue.sv =====
module nscan_result_queue
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  nscan_pkg::result_push_t       push,
    input  logic                          pop,
    output nscan_pkg::nal_result_t        head,
    output logic [nscan_pkg::QCNT_W-1:0]  count
);

    nscan_pkg::nal_result_t              entry_reg [nscan_pkg::QDEPTH];
    logic [nscan_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [nscan_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [nscan_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic [nscan_pkg::QPTR_W-1:0]        wr_ptr_second;

    assign wr_ptr_second = wr_ptr_reg + nscan_pkg::QPTR_W'(1);
    assign wr_ptr_next   = wr_ptr_reg + nscan_pkg::QPTR_W'(push.count);
    assign rd_ptr_next   = rd_ptr_reg + nscan_pkg::QPTR_W'(pop);
    assign count_next    = count_reg + nscan_pkg::QCNT_W'(push.count)
                         - nscan_pkg::QCNT_W'(pop);
    assign head          = entry_reg[rd_ptr_reg];
    assign count         = count_reg;

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_second] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    typedef struct {
        logic [7:0] data;
        logic       pkt_start;
        logic       pkt_end;
    } byte_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    nscan_byte_if  stream_if();
    nscan_event_if event_if();

    nal_start_code_scanner_core dut
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream_if),
        .nal_events (event_if)
    );

    always #5 clk = ~clk;

    byte_item_t             pending_bytes[$];
    nscan_pkg::nal_result_t expected_events[$];
    int                     total_bytes;
    int                     bytes_taken;
    int                     errors;

    // scanner state as predicted
    logic [1:0] scan_zeros;
    logic       type_due;
    int         scan_pos;
    logic       unit_here;
    logic [1:0] carried_zeros;

    function automatic int step_pos(input int p);
        return (p >= int'(nscan_pkg::POS_TOP)) ? int'(nscan_pkg::POS_TOP) : p + 1;
    endfunction

    // where the previous unit ends for a start code whose 0x01 sits just before i
    function automatic nscan_pkg::nal_result_t prev_fields(input nscan_pkg::nal_result_t r,
                                                           input int i);
        int z;
        z = int'(scan_zeros);
        r.prev_end_offset = (i >= 1 + z) ? nscan_pkg::POS_W'(i - 1 - z) : '0;
        r.prev_in_packet = unit_here;
        r.strip_prev = (!unit_here && carried_zeros != 2'd0 && i + int'(carried_zeros) <= 4)
                       ? carried_zeros : 2'd0;
        return r;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic st, input logic en);
        nscan_pkg::nal_result_t r;
        nscan_pkg::nal_result_t outs[$];
        int                     p;
        if (st)
        begin
            carried_zeros = type_due ? 2'd0 : scan_zeros;
            scan_pos = 0;
            unit_here = 1'b0;
        end
        p = scan_pos;
        if (type_due)
        begin
            r = '0;
            r.event_kind = nscan_pkg::EV_UNIT_START;
            r.nal_type = b[4:0] & nscan_pkg::TYPE_MASK[4:0];
            r.unit_offset = nscan_pkg::POS_W'(p);
            if (!st)
                r = prev_fields(r, p);
            unit_here = 1'b1;
            type_due = 1'b0;
            scan_zeros = st ? 2'd0 : ((b == 8'h00) ? 2'd1 : 2'd0);
            outs.push_back(r);
        end
        else if (scan_zeros < 2'd2)
            scan_zeros = (b != 8'h00) ? 2'd0 : scan_zeros + 2'd1;
        else if (b == 8'h00)
            scan_zeros = nscan_pkg::ZERO_RUN_TOP;
        else if (b == 8'h01)
            type_due = 1'b1;
        else
            scan_zeros = 2'd0;

        if (en)
        begin
            r = '0;
            r.event_kind = nscan_pkg::EV_PACKET_END;
            if (type_due)
            begin
                r = prev_fields(r, step_pos(p));
                r.type_pending = 1'b1;
            end
            else
            begin
                r.prev_end_offset = nscan_pkg::POS_W'(step_pos(p));
                r.prev_in_packet = unit_here;
                r.trailing_zeros = scan_zeros;
            end
            outs.push_back(r);
        end
        if (outs.size() > 0)
            outs[outs.size() - 1].last = 1'b1;
        foreach (outs[k])
            expected_events.push_back(outs[k]);
        scan_pos = step_pos(p);
    endtask

    function automatic int pick_idle(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 8)
        begin
            calm = $urandom_range(50, 200);
            return 0;
        end
        if (r < 600)
            return 0;
        if (r < 970)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // byte driver
    int         src_gap;
    int         src_calm;
    byte_item_t next_byte;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_if.valid        <= 1'b0;
            stream_if.data_byte    <= 8'h00;
            stream_if.packet_start <= 1'b0;
            stream_if.packet_end   <= 1'b0;
            src_gap = 0;
            src_calm = 0;
        end
        else
        begin
            if (stream_if.valid && stream_if.ready)
            begin
                scan_byte(stream_if.data_byte, stream_if.packet_start, stream_if.packet_end);
                bytes_taken++;
            end
            if (!stream_if.valid || stream_if.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    stream_if.valid <= 1'b0;
                end
                else if (pending_bytes.size() > 0)
                begin
                    next_byte = pending_bytes.pop_front();
                    stream_if.valid        <= 1'b1;
                    stream_if.data_byte    <= next_byte.data;
                    stream_if.packet_start <= next_byte.pkt_start;
                    stream_if.packet_end   <= next_byte.pkt_end;
                    src_gap = pick_idle(src_calm);
                end
                else
                    stream_if.valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input int exp_val, input int got_val);
        if (exp_val != got_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endtask

    // event monitor
    logic                   hold_sink;
    int                     sink_stall;
    int                     sink_calm;
    nscan_pkg::nal_result_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_if.ready <= 1'b0;
            sink_stall = 0;
            sink_calm = 0;
        end
        else
        begin
            if (event_if.valid && event_if.ready)
            begin
                if (expected_events.size() == 0)
                begin
                    $error("unexpected event: kind %0d type %0d offset %0d",
                           event_if.event_kind, event_if.nal_type, event_if.unit_offset);
                    errors++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", int'(want.event_kind), int'(event_if.event_kind));
                    check_field("nal_type", want.nal_type, event_if.nal_type);
                    check_field("unit_offset", want.unit_offset, event_if.unit_offset);
                    check_field("prev_end_offset", want.prev_end_offset,
                                event_if.prev_end_offset);
                    check_field("prev_in_packet", want.prev_in_packet, event_if.prev_in_packet);
                    check_field("strip_prev", want.strip_prev, event_if.strip_prev);
                    check_field("trailing_zeros", want.trailing_zeros, event_if.trailing_zeros);
                    check_field("type_pending", want.type_pending, event_if.type_pending);
                    check_field("last", want.last, event_if.last);
                end
            end
            if (hold_sink)
                event_if.ready <= 1'b0;
            else if (sink_stall > 0)
            begin
                sink_stall--;
                event_if.ready <= 1'b0;
            end
            else
            begin
                event_if.ready <= 1'b1;
                sink_stall = pick_idle(sink_calm);
            end
        end
    end

    // long hold-off on the event side while bytes are still offered
    initial
    begin
        hold_sink = 1'b0;
        while (bytes_taken < 500)
            @(posedge clk);
        hold_sink <= 1'b1;
        repeat (300) @(posedge clk);
        hold_sink <= 1'b0;
    end

    task automatic push_byte(input logic [7:0] b, input logic st, input logic en);
        byte_item_t it;
        it.data = b;
        it.pkt_start = st;
        it.pkt_end = en;
        pending_bytes.push_back(it);
    endtask

    task automatic push_packet(input logic [7:0] bytes[$], input logic st, input logic en);
        foreach (bytes[k])
            push_byte(bytes[k], st && k == 0, en && k == bytes.size() - 1);
    endtask

    // well-formed start codes with random content, broken ones and noise, cut into packets
    task automatic push_random_stream(input int count);
        logic [7:0] seg[$];
        int         n;
        int         plen;
        int         idx;
        int         r;
        while (seg.size() < count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    n = $urandom_range(2, 4);
                    repeat (n) seg.push_back(8'h00);
                    seg.push_back(8'h01);
                    seg.push_back(($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
                end
                4, 5:
                begin
                    n = $urandom_range(1, 3);
                    repeat (n) seg.push_back(8'h00);
                    seg.push_back(8'($urandom_range(1, 255)));
                end
                6:
                begin
                    seg.push_back(8'h00);
                    seg.push_back(8'h00);
                    seg.push_back(8'($urandom_range(2, 255)));
                end
                7:
                begin
                    seg.push_back(8'h00);
                    seg.push_back(8'h01);
                end
                default:
                begin
                    n = $urandom_range(1, 6);
                    repeat (n) seg.push_back(8'($urandom_range(0, 255)));
                end
            endcase
        end
        idx = 0;
        while (idx < seg.size())
        begin
            r = $urandom_range(0, 99);
            plen = (r < 50) ? $urandom_range(1, 8) :
                   (r < 90) ? $urandom_range(9, 60) : $urandom_range(61, 300);
            for (int k = 0; k < plen && idx < seg.size(); k++)
            begin
                push_byte(seg[idx], k == 0 && $urandom_range(0, 19) != 0,
                          (k == plen - 1 || idx == seg.size() - 1) && $urandom_range(0, 19) != 0);
                idx++;
            end
        end
    endtask

    initial
    begin
        logic [7:0] pkt[$];
        scan_zeros = 2'd0;
        type_due = 1'b0;
        scan_pos = 0;
        unit_here = 1'b0;
        carried_zeros = 2'd0;
        bytes_taken = 0;
        errors = 0;

        // zero run saturation, type byte on the packet's last byte
        pkt = '{8'h00, 8'h00, 8'h01, 8'h65, 8'hff, 8'h00, 8'h00, 8'h00, 8'h01, 8'h09};
        push_packet(pkt, 1'b1, 1'b1);
        // start code split across packets
        pkt = '{8'h00, 8'h00};
        push_packet(pkt, 1'b1, 1'b1);
        pkt = '{8'h01, 8'h67, 8'h00};
        push_packet(pkt, 1'b1, 1'b1);
        // type byte carried into the next packet
        pkt = '{8'h00, 8'h00, 8'h01};
        push_packet(pkt, 1'b1, 1'b1);
        pkt = '{8'h1f, 8'he0};
        push_packet(pkt, 1'b1, 1'b1);
        // pending type read from a byte without packet start
        pkt = '{8'h00, 8'h00, 8'h01};
        push_packet(pkt, 1'b1, 1'b1);
        push_byte(8'h41, 1'b0, 1'b1);
        push_byte(8'h00, 1'b1, 1'b1);

        push_random_stream(1800);
        pkt = '{8'h05};
        push_packet(pkt, 1'b1, 1'b1);
        push_random_stream(40);
        total_bytes = pending_bytes.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (bytes_taken < total_bytes)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        #100ms;
        $display("tb: FAIL");
        $finish;
    end

endmodule
